// ----- rtl/core/beg_pkg.sv -----
// Shared types and constants for the button event generator.
package beg_pkg;

    // Widest button count the design supports.
    localparam int MAX_BUTTONS = 16;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Width of the button level field in an input transaction.
    localparam int LEVEL_W = 7;

    // Input transaction kinds.
    localparam logic [1:0] KIND_POLL   = 2'd0;
    localparam logic [1:0] KIND_RESYNC = 2'd1;
    localparam logic [1:0] KIND_IDLE   = 2'd2;

    // Result event codes.
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_PRESS   = 3'd1;
    localparam logic [2:0] EV_RELEASE = 3'd2;
    localparam logic [2:0] EV_REPEAT  = 3'd3;
    localparam logic [2:0] EV_LONG    = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MASK     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_START    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS      = 2'd3;

    // Configuration reset values.
    localparam logic [LEVEL_W-1:0] RST_REPEAT_MASK     = 7'd15;
    localparam logic [15:0]        RST_REPEAT_START    = 16'd500;
    localparam logic [15:0]        RST_REPEAT_INTERVAL = 16'd150;
    localparam logic [15:0]        RST_LONG_PRESS      = 16'd1000;

    // One input transaction.
    typedef struct packed {
        logic [1:0]         kind;
        logic [LEVEL_W-1:0] buttons;
        logic [31:0]        now_ms;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic [2:0]  event_kind;
        logic [2:0]  button;
        logic [31:0] idle_ms;
        logic        last;
    } t_out_item;

endpackage

// ----- rtl/core/button_event_generator_unit.sv -----
// Top level of the button event generator: evaluation core and result serializer.
// An accepted transaction's first result appears in the cycle after acceptance when the serializer is free.
// A transaction with k events yields k + 1 results, so up to NUM_BUTTONS + 1;
// the holding register takes one more transaction while the serializer drains the current one.
// Reset: synchronous, active low; clears the valid flags and button timing state and loads the register defaults.
module button_event_generator_unit #(
    parameter int NUM_BUTTONS = 7
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [beg_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [beg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  beg_pkg::t_in_item               i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output beg_pkg::t_out_item              o_out
);
    import beg_pkg::*;

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    logic                           in_fire;
    logic                           out_fire;
    logic [NUM_BUTTONS-1:0]         evt_mask;
    logic [NUM_BUTTONS-1:0][2:0]    evt_kind;
    logic [31:0]                    evt_idle;

    // Serializer: current transaction being drained and one held behind it.
    logic                           r_cur_vld;
    logic [NUM_BUTTONS-1:0]         r_cur_pend;
    logic [NUM_BUTTONS-1:0][2:0]    r_cur_kind;
    logic [31:0]                    r_cur_idle;
    logic                           r_hold_vld;
    logic [NUM_BUTTONS-1:0]         r_hold_pend;
    logic [NUM_BUTTONS-1:0][2:0]    r_hold_kind;
    logic [31:0]                    r_hold_idle;

    logic [IDX_W-1:0]               sel;
    logic [3:0]                     sel_wide;
    logic                           cur_done;
    logic                           load_cur;

    assign o_in_ready = !r_hold_vld;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_fire   = o_out_valid && i_out_ready;

    beg_core #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (in_fire),
        .i_item     (i_in),
        .o_evt_mask (evt_mask),
        .o_evt_kind (evt_kind),
        .o_idle_ms  (evt_idle)
    );

    // Lowest pending button goes out first.
    always_comb begin
        sel = '0;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
            if (r_cur_pend[i]) begin
                sel = IDX_W'(i);
            end
        end
    end
    assign sel_wide = 4'(sel);

    // Result payload: an event while any remain, then the closing status result.
    always_comb begin
        o_out_valid = r_cur_vld;
        if (|r_cur_pend) begin
            o_out.event_kind = r_cur_kind[sel];
            o_out.button     = sel_wide[2:0];
            o_out.idle_ms    = 32'd0;
            o_out.last       = 1'b0;
        end else begin
            o_out.event_kind = EV_NONE;
            o_out.button     = 3'd0;
            o_out.idle_ms    = r_cur_idle;
            o_out.last       = 1'b1;
        end
    end

    assign cur_done = out_fire && !(|r_cur_pend);
    assign load_cur = !r_cur_vld || cur_done;

    // Serializer control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vld  <= 1'b0;
            r_hold_vld <= 1'b0;
        end else if (load_cur) begin
            r_cur_vld  <= r_hold_vld || in_fire;
            r_hold_vld <= 1'b0;
        end else if (in_fire) begin
            r_hold_vld <= 1'b1;
        end
    end

    // Serializer payload.
    always_ff @(posedge i_clk) begin
        if (load_cur) begin
            if (r_hold_vld) begin
                r_cur_pend <= r_hold_pend;
                r_cur_kind <= r_hold_kind;
                r_cur_idle <= r_hold_idle;
            end else begin
                r_cur_pend <= evt_mask;
                r_cur_kind <= evt_kind;
                r_cur_idle <= evt_idle;
            end
        end else begin
            if (out_fire) begin
                r_cur_pend <= r_cur_pend & (r_cur_pend - NUM_BUTTONS'(1));
            end
            if (in_fire) begin
                r_hold_pend <= evt_mask;
                r_hold_kind <= evt_kind;
                r_hold_idle <= evt_idle;
            end
        end
    end

`ifndef SYNTHESIS
    // A held transaction always sits behind one being drained.
    a_hold_behind_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_vld |-> r_cur_vld)
        else $error("holding register full while serializer is empty");

    // An accepted transaction always leaves something to deliver.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_cur_vld)
        else $error("accepted transaction produced no pending result");

    // Event results never carry the closing flag or an idle time.
    a_event_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.event_kind != EV_NONE))
            |-> (!o_out.last && (o_out.idle_ms == 32'd0)))
        else $error("event result carries status fields");
`endif

endmodule

// ----- rtl/core/beg_core.sv -----
// Per-button event evaluation, button timing state and configuration registers.
module beg_core #(
    parameter int NUM_BUTTONS = 7
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [beg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [beg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_fire,
    input  beg_pkg::t_in_item                i_item,
    output logic [NUM_BUTTONS-1:0]           o_evt_mask,
    output logic [NUM_BUTTONS-1:0][2:0]      o_evt_kind,
    output logic [31:0]                      o_idle_ms
);
    import beg_pkg::*;

    // Configuration registers.
    logic [LEVEL_W-1:0] r_repeat_mask;
    logic [15:0]        r_repeat_start;
    logic [15:0]        r_repeat_interval;
    logic [15:0]        r_long_press;

    // Button timing state.
    logic [NUM_BUTTONS-1:0]       r_prev;
    logic [NUM_BUTTONS-1:0][31:0] r_press_time;
    logic [NUM_BUTTONS-1:0][31:0] r_repeat_time;
    logic [NUM_BUTTONS-1:0]       r_long_done;
    logic [31:0]                  r_activity;

    logic [MAX_BUTTONS-1:0] lvl_pad;
    logic [MAX_BUTTONS-1:0] mask_pad;
    logic [NUM_BUTTONS-1:0] lvl;
    logic [NUM_BUTTONS-1:0] rep_en;
    logic [NUM_BUTTONS-1:0] ev_press;
    logic [NUM_BUTTONS-1:0] ev_release;
    logic [NUM_BUTTONS-1:0] ev_repeat;
    logic [NUM_BUTTONS-1:0] ev_long;
    logic                   is_poll;
    logic                   any_activity;
    logic                   idle_zero;

    // Buttons beyond the level field read as released and as long-press buttons.
    assign lvl_pad  = MAX_BUTTONS'(i_item.buttons);
    assign mask_pad = MAX_BUTTONS'(r_repeat_mask);
    assign lvl      = lvl_pad[NUM_BUTTONS-1:0];
    assign rep_en   = mask_pad[NUM_BUTTONS-1:0];
    assign is_poll  = (i_item.kind == KIND_POLL);

    // Per-button lanes: edge detection and hold timing, all in parallel.
    always_comb begin
        logic [31:0] since_rep;
        logic [31:0] since_press;
        logic [15:0] thr;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            since_rep     = i_item.now_ms - r_repeat_time[i];
            since_press   = i_item.now_ms - r_press_time[i];
            thr           = (r_repeat_time[i] == r_press_time[i]) ? r_repeat_start
                                                                  : r_repeat_interval;
            ev_press[i]   = is_poll && lvl[i] && !r_prev[i];
            ev_release[i] = is_poll && !lvl[i] && r_prev[i];
            ev_repeat[i]  = is_poll && lvl[i] && r_prev[i] && rep_en[i]
                            && (since_rep >= 32'(thr));
            ev_long[i]    = is_poll && lvl[i] && r_prev[i] && !rep_en[i]
                            && !r_long_done[i] && (since_press >= 32'(r_long_press));
            o_evt_mask[i] = ev_press[i] | ev_release[i] | ev_repeat[i] | ev_long[i];
            if (ev_press[i]) begin
                o_evt_kind[i] = EV_PRESS;
            end else if (ev_release[i]) begin
                o_evt_kind[i] = EV_RELEASE;
            end else if (ev_repeat[i]) begin
                o_evt_kind[i] = EV_REPEAT;
            end else if (ev_long[i]) begin
                o_evt_kind[i] = EV_LONG;
            end else begin
                o_evt_kind[i] = EV_NONE;
            end
        end
    end

    // Idle time: zero when this transaction refreshes the activity time.
    assign any_activity = |(ev_press | ev_release | ev_repeat);
    assign idle_zero    = any_activity || (i_item.kind == KIND_IDLE);
    assign o_idle_ms    = idle_zero ? 32'd0 : (i_item.now_ms - r_activity);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_mask     <= RST_REPEAT_MASK;
            r_repeat_start    <= RST_REPEAT_START;
            r_repeat_interval <= RST_REPEAT_INTERVAL;
            r_long_press      <= RST_LONG_PRESS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REPEAT_MASK:     r_repeat_mask     <= i_cfg_data[LEVEL_W-1:0];
                CFG_REPEAT_START:    r_repeat_start    <= i_cfg_data;
                CFG_REPEAT_INTERVAL: r_repeat_interval <= i_cfg_data;
                CFG_LONG_PRESS:      r_long_press      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // State update on each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev        <= '0;
            r_press_time  <= '0;
            r_repeat_time <= '0;
            r_long_done   <= '0;
            r_activity    <= '0;
        end else if (i_fire) begin
            if (is_poll || (i_item.kind == KIND_RESYNC)) begin
                r_prev <= lvl;
            end
            if (idle_zero) begin
                r_activity <= i_item.now_ms;
            end
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                if (ev_press[i]) begin
                    r_press_time[i]  <= i_item.now_ms;
                    r_repeat_time[i] <= i_item.now_ms;
                    r_long_done[i]   <= 1'b0;
                end else if (ev_repeat[i]) begin
                    r_repeat_time[i] <= i_item.now_ms;
                end else if (ev_long[i]) begin
                    r_long_done[i]   <= 1'b1;
                end
            end
        end
    end

endmodule
